>>> design/pcm8us_pkg.sv
// Shared types and constants for the PCM8 upsampler with low-pass filter.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package pcm8us_pkg;

  // Default geometry of the position and phase counters
  localparam int unsigned LengthBitsDef = 24;
  localparam int unsigned FracBitsDef   = 16;

  // At most this many outputs per source byte
  localparam int unsigned MaxRun = 16;
  localparam int unsigned RunW   = $clog2(MaxRun + 1);

  // Register file: 32-bit data, registers at byte addresses 0, 4, 8
  localparam int unsigned AddrW     = 4;
  localparam int unsigned DataW     = 32;
  localparam logic [15:0] StepReset  = 16'd41610;
  localparam logic [23:0] LenReset   = 24'd1;
  localparam logic [15:0] AlphaReset = 16'd43652;

  typedef enum logic [1:0] {
    REG_STEP_RATIO    = 2'd0,
    REG_OUTPUT_LENGTH = 2'd1,
    REG_ALPHA         = 2'd2
  } reg_idx_e;

  // One source item
  typedef struct packed {
    logic [7:0] source_byte;
    logic       first;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic signed [15:0] sample;
    logic               last_in_run;
    logic               sound_done;
  } out_item_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_EMIT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_in;  // latch the accepted byte, rewind on first
    logic mul;      // register alpha * (x - prev)
    logic emit;     // finish the filter and load the output register
    logic finish;   // advance the source position
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cont;       // another output is owed on the current state
    logic cont_next;  // another output is owed after the one being emitted
    logic out_free;   // output register can take a beat this cycle
  } status_t;

endpackage

>>> design/pcm8_upsampler_with_lowpass_unit.sv
// Top level of the PCM8 upsampler with one-pole low-pass filter.
// Depends on pcm8us_pkg, pcm8us_ctrl and pcm8us_datapath.
//
//   port group   direction   beat / transfer
//   in_*         input       one source byte and its first flag
//   out_*        output      one filtered 16-bit sample with run/done flags
//   APB          input       register write or read, one per access phase
//
// A source byte is taken in the idle step and its run is tested in the eval step;
// then each of the n (0..16) samples it yields passes a multiply step and an emit
// step, since each filtered sample needs the previous one through the shared
// multiplier and the accumulate that follows it.
// Reset clears all positions and the filter history and loads register defaults.
// An output stall holds the sequencer at the emit step; the output register
// lets a new byte be taken while its last sample still waits.
`timescale 1ns / 1ps

module pcm8_upsampler_with_lowpass_unit #(
  parameter int unsigned LENGTH_BITS = pcm8us_pkg::LengthBitsDef,
  parameter int unsigned FRAC_BITS   = pcm8us_pkg::FracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pcm8us_pkg::AddrW-1:0] paddr,
  input  logic [pcm8us_pkg::DataW-1:0] pwdata,
  output logic [pcm8us_pkg::DataW-1:0] prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  pcm8us_pkg::in_item_t         in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output pcm8us_pkg::out_item_t        out_data_o
);
  import pcm8us_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  pcm8us_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Registers, counters and filter
  pcm8us_datapath #(
    .LENGTH_BITS (LENGTH_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

>>> design/pcm8us_ctrl.sv
// Sequencer for the PCM8 upsampler: steps each source byte through its run.
// Depends on pcm8us_pkg.
`timescale 1ns / 1ps

module pcm8us_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pcm8us_pkg::status_t status_i,
  output pcm8us_pkg::cmd_t    cmd_o
);
  import pcm8us_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (status_i.cont) begin
          state_d = ST_MUL;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register has room
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.cont_next) begin
            state_d = ST_MUL;
          end else begin
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/pcm8us_datapath.sv
// Datapath of the PCM8 upsampler: registers, positions, phase, filter, output.
// Depends on pcm8us_pkg; driven by pcm8us_ctrl.
`timescale 1ns / 1ps

module pcm8us_datapath #(
  parameter int unsigned LENGTH_BITS = pcm8us_pkg::LengthBitsDef,
  parameter int unsigned FRAC_BITS   = pcm8us_pkg::FracBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pcm8us_pkg::AddrW-1:0]       paddr,
  input  logic [pcm8us_pkg::DataW-1:0]       pwdata,
  output logic [pcm8us_pkg::DataW-1:0]       prdata,
  output logic                               pready,
  input  pcm8us_pkg::in_item_t               in_data_i,
  output pcm8us_pkg::out_item_t              out_data_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  input  pcm8us_pkg::cmd_t                   cmd_i,
  output pcm8us_pkg::status_t                status_o
);
  import pcm8us_pkg::*;

  localparam int unsigned PhaseW = LENGTH_BITS + FRAC_BITS;
  localparam logic [15:0] StepMask =
    (FRAC_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << FRAC_BITS) - 32'd1);

  // Configuration registers
  logic [15:0]            step_q, step_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [15:0]            alpha_q, alpha_d;

  // Sound state
  logic [LENGTH_BITS-1:0] out_pos_q, out_pos_d;
  logic [PhaseW-1:0]      phase_q, phase_d;
  logic [LENGTH_BITS-1:0] src_pos_q, src_pos_d;
  logic signed [15:0]     prev_q, prev_d;
  logic [RunW-1:0]        run_q, run_d;

  // Working payload
  logic signed [15:0]     x_q, x_d;
  logic signed [33:0]     prod_q, prod_d;
  out_item_t              out_q, out_d;
  logic                   out_valid_q, out_valid_d;

  // Combinational helpers
  logic                   cfg_wr;
  reg_idx_e               reg_idx;
  logic [LENGTH_BITS-1:0] out_pos_inc;
  logic [PhaseW-1:0]      phase_add;
  logic [RunW-1:0]        run_inc;
  logic signed [16:0]     diff;
  logic signed [16:0]     alpha_s;
  logic signed [34:0]     sum;
  logic [18:0]            quot;
  logic                   round_up;
  logic signed [15:0]     filt;
  logic signed [15:0]     y;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  // Register readback
  always_comb begin
    case (reg_idx)
      REG_STEP_RATIO:    prdata = {16'h0, step_q};
      REG_OUTPUT_LENGTH: prdata = DataW'(len_q);
      REG_ALPHA:         prdata = {16'h0, alpha_q};
      default:           prdata = '0;
    endcase
  end

  // Loop conditions on the current state and on the state after an emit
  assign out_pos_inc = out_pos_q + LENGTH_BITS'(1);
  assign phase_add   = phase_q + PhaseW'(step_q);
  assign run_inc     = run_q + RunW'(1);

  assign status_o.cont = (run_q < RunW'(MaxRun)) && (out_pos_q < len_q) &&
                         (phase_q[PhaseW-1:FRAC_BITS] <= src_pos_q);
  assign status_o.cont_next = (run_inc < RunW'(MaxRun)) && (out_pos_inc < len_q) &&
                              (phase_add[PhaseW-1:FRAC_BITS] <= src_pos_q);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  // Filter: y = (prev*65536 + alpha*(x - prev)) / 65536, truncated toward zero
  assign diff     = {x_q[15], x_q} - {prev_q[15], prev_q};
  assign alpha_s  = {1'b0, alpha_q};
  assign prod_d   = alpha_s * diff;
  assign sum      = {{3{prev_q[15]}}, prev_q, 16'h0} + {prod_q[33], prod_q};
  assign quot     = sum[34:16];
  assign round_up = sum[34] && (sum[15:0] != 16'h0);
  assign filt     = quot[15:0] + 16'(round_up);
  assign y        = (out_pos_q == '0) ? x_q : filt;

  // Next values
  always_comb begin
    step_d      = step_q;
    len_d       = len_q;
    alpha_d     = alpha_q;
    out_pos_d   = out_pos_q;
    phase_d     = phase_q;
    src_pos_d   = src_pos_q;
    prev_d      = prev_q;
    run_d       = run_q;
    x_d         = x_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (cfg_wr) begin
      case (reg_idx)
        REG_STEP_RATIO:    step_d  = pwdata[15:0] & StepMask;
        REG_OUTPUT_LENGTH: len_d   = LENGTH_BITS'(pwdata[23:0]);
        REG_ALPHA:         alpha_d = pwdata[15:0];
        default:           ;
      endcase
    end

    // latch the byte widened to signed 16 bits, rewind on first
    if (cmd_i.load_in) begin
      x_d   = {~in_data_i.source_byte[7], in_data_i.source_byte[6:0],
               in_data_i.source_byte};
      run_d = '0;
      if (in_data_i.first) begin
        out_pos_d = '0;
        phase_d   = '0;
        src_pos_d = '0;
      end
    end

    // produce one output beat and advance
    if (cmd_i.emit) begin
      prev_d            = y;
      out_pos_d         = out_pos_inc;
      phase_d           = phase_add;
      run_d             = run_inc;
      out_d.sample      = y;
      out_d.last_in_run = !status_o.cont_next;
      out_d.sound_done  = (out_pos_inc >= len_q);
      out_valid_d       = 1'b1;
    end

    if (cmd_i.finish) begin
      src_pos_d = src_pos_q + LENGTH_BITS'(1);
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= StepReset & StepMask;
      len_q       <= LENGTH_BITS'(LenReset);
      alpha_q     <= AlphaReset;
      out_pos_q   <= '0;
      phase_q     <= '0;
      src_pos_q   <= '0;
      prev_q      <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      len_q       <= len_d;
      alpha_q     <= alpha_d;
      out_pos_q   <= out_pos_d;
      phase_q     <= phase_d;
      src_pos_q   <= src_pos_d;
      prev_q      <= prev_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    out_q <= out_d;
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
  end

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule

>>> design/pcm8us_checker.sv
// Port-level checks for the PCM8 upsampler, bound to its top level.
// Depends on pcm8us_pkg and pcm8_upsampler_with_lowpass_unit.
`timescale 1ns / 1ps

module pcm8us_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input pcm8us_pkg::out_item_t out_data_o
);
  import pcm8us_pkg::*;

  // A taken byte keeps the input stalled while its run is tested
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after a byte was taken");

  // The beat that ends the sound also ends its run
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.sound_done) |-> out_data_o.last_in_run)
    else $error("sound_done without last_in_run");

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled output beat changed");

  // Output valid drops only after a beat was taken
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("output valid dropped while stalled");

endmodule

bind pcm8_upsampler_with_lowpass_unit pcm8us_checker u_pcm8us_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

>>> test/tb.sv
// Self-checking testbench for pcm8_upsampler_with_lowpass_unit.
// Drives source bytes and APB register writes, predicts every filtered sample
// in SystemVerilog and checks each output beat. Depends on pcm8us_pkg.
`timescale 1ns / 1ps

module tb;
  import pcm8us_pkg::*;

  localparam int LenW         = LengthBitsDef;
  localparam int FracW        = FracBitsDef;
  localparam int PhaseW       = LenW + FracW;
  localparam int CycleLimit   = 5_000_000;
  localparam int HoldCycles   = 400;
  localparam int SettleCycles = 40;
  localparam int RandomBytes  = 450;

  typedef enum logic {
    ROW_REGS,
    ROW_BYTE
  } row_kind_e;

  // One row of the directed stimulus: a register setting or a source byte
  typedef struct packed {
    row_kind_e          kind;
    logic [15:0]        step;
    logic [23:0]        len;
    logic [15:0]        alpha;
    in_item_t           beat;
    logic               typed;
    logic signed [15:0] typed_sample;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_data_o;

  // Shadow registers and resampler state
  logic [15:0]        cfg_step;
  logic [LenW-1:0]    cfg_len;
  logic [15:0]        cfg_alpha;
  logic [LenW-1:0]    out_pos;
  logic [LenW-1:0]    src_pos;
  logic [PhaseW-1:0]  phase;
  logic signed [15:0] last_sample;

  out_item_t pending_samples[$];
  stim_row_t directed_rows[$];
  int        errors;
  int        cycles;
  bit        hold_req;
  bit        hold_seen;

  pcm8_upsampler_with_lowpass_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Bound the run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input longint want, input longint got);
    errors++;
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  // Hold each source byte over the outputs its phase span covers, filter them
  // and queue the resulting samples
  task automatic upsample_byte(input in_item_t beat, input bit typed,
                               input logic signed [15:0] typed_sample);
    int                 n;
    logic signed [15:0] x;
    logic signed [15:0] y;
    longint             acc;
    out_item_t          r;
    n = 0;
    if (beat.first) begin
      out_pos = '0;
      phase   = '0;
      src_pos = '0;
    end
    x = 16'(int'(beat.source_byte) * 257 - 32768);
    while (n < MaxRun && out_pos < cfg_len && phase[PhaseW-1:FracW] <= src_pos) begin
      // first output of a sound bypasses the filter
      if (out_pos == '0) begin
        y = x;
      end else begin
        acc = longint'(cfg_alpha) * longint'(x) +
              (65536 - longint'(cfg_alpha)) * longint'(last_sample);
        y = 16'(acc / 65536);
      end
      last_sample = y;
      out_pos     = out_pos + 1'b1;
      phase       = phase + PhaseW'(cfg_step);
      r.sample      = (typed && n == 0) ? typed_sample : y;
      r.last_in_run = 1'b0;
      r.sound_done  = (out_pos >= cfg_len);
      pending_samples.push_back(r);
      n++;
    end
    // mark the final sample of this byte
    if (n > 0) begin
      r = pending_samples.pop_back();
      r.last_in_run = 1'b1;
      pending_samples.push_back(r);
    end
    src_pos = src_pos + 1'b1;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one beat until taken, then idle for a random gap, possibly none
  task automatic send_byte(input in_item_t beat, input bit typed,
                           input logic signed [15:0] typed_sample, input bit no_gap);
    int gap;
    in_data_i  <= beat;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    upsample_byte(beat, typed, typed_sample);
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid, wait out every queued sample, then let trailing bytes finish
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // APB write followed by a read-back of the same register
  task automatic write_reg(input reg_idx_e idx, input logic [DataW-1:0] value);
    logic [DataW-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_STEP_RATIO:    cfg_step  = value[15:0];
      REG_OUTPUT_LENGTH: cfg_len   = value[LenW-1:0];
      REG_ALPHA:         cfg_alpha = value[15:0];
      default: ;
    endcase
    @(posedge clk_i);
    psel   <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== value) flag_mismatch("register read-back", value, rd);
    @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [15:0] step, input logic [23:0] len,
                          input logic [15:0] alpha);
    settle_block();
    write_reg(REG_STEP_RATIO, DataW'(step));
    write_reg(REG_OUTPUT_LENGTH, DataW'(len));
    write_reg(REG_ALPHA, DataW'(alpha));
  endtask

  task automatic add_regs(input logic [15:0] step, input logic [23:0] len,
                          input logic [15:0] alpha);
    stim_row_t row;
    row       = '0;
    row.kind  = ROW_REGS;
    row.step  = step;
    row.len   = len;
    row.alpha = alpha;
    directed_rows.push_back(row);
  endtask

  task automatic add_byte(input logic [7:0] b, input logic first, input logic typed,
                          input logic signed [15:0] typed_sample);
    stim_row_t row;
    row                  = '0;
    row.kind             = ROW_BYTE;
    row.beat.source_byte = b;
    row.beat.first       = first;
    row.typed            = typed;
    row.typed_sample     = typed_sample;
    directed_rows.push_back(row);
  endtask

  // Check each output beat against the oldest queued sample
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (pending_samples.size() == 0) begin
        errors++;
        $display("%0t ns: sample mismatch, expected no beat, got %0d",
                 $time, out_data_o.sample);
      end else begin
        want = pending_samples.pop_front();
        if (out_data_o.sample !== want.sample)
          flag_mismatch("sample", want.sample, out_data_o.sample);
        if (out_data_o.last_in_run !== want.last_in_run)
          flag_mismatch("last_in_run", want.last_in_run, out_data_o.last_in_run);
        if (out_data_o.sound_done !== want.sound_done)
          flag_mismatch("sound_done", want.sound_done, out_data_o.sound_done);
      end
    end
  end

  // Output backpressure: short stalls, quiet stretches and one long hold-off
  initial begin
    int run_left;
    int r;
    out_stall_i <= 1'b0;
    run_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        out_stall_i <= 1'b1;
        run_left = HoldCycles;
      end else if (run_left > 0) begin
        run_left--;
      end else if (out_stall_i) begin
        out_stall_i <= 1'b0;
        run_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 5)
                                                : $urandom_range(20, 80);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          run_left = $urandom_range(0, 5);
        end else begin
          out_stall_i <= 1'b1;
          run_left = (r < 90) ? $urandom_range(0, 2) : $urandom_range(9, 39);
        end
      end
    end
  end

  // Stimulus
  initial begin
    int          random_sent;
    int          seq_len;
    int          r;
    bit          held;
    bit          burst;
    bit          fresh;
    in_item_t    beat;
    logic [15:0] step;
    logic [23:0] len;
    logic [15:0] alpha;

    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    errors      = 0;
    cycles      = 0;
    hold_req    = 1'b0;
    hold_seen   = 1'b0;
    held        = 1'b0;
    random_sent = 0;
    cfg_step    = StepReset;
    cfg_len     = LenReset;
    cfg_alpha   = AlphaReset;
    out_pos     = '0;
    src_pos     = '0;
    phase       = '0;
    last_sample = '0;

    // reset defaults: one raw sample, then the sound is over
    add_byte(8'h80, 1'b0, 1'b1, 16'sd128);
    add_byte(8'h00, 1'b0, 1'b0, '0);
    // full-weight filter, sixteen outputs per byte, sound ends mid-run
    add_regs(16'd4096, 24'd40, 16'd65535);
    add_byte(8'h00, 1'b1, 1'b1, -16'sd32768);
    add_byte(8'hFF, 1'b0, 1'b0, '0);
    add_byte(8'h55, 1'b0, 1'b0, '0);
    add_byte(8'hAA, 1'b0, 1'b0, '0);
    // largest step, filter frozen on the first sample
    add_regs(16'd65535, 24'd300, 16'd0);
    add_byte(8'hFF, 1'b1, 1'b1, 16'sd32767);
    add_byte(8'h00, 1'b0, 1'b0, '0);
    add_byte(8'h01, 1'b0, 1'b0, '0);
    // zero step: every byte repeats to the run limit until the length
    add_regs(16'd0, 24'd50, 16'd32768);
    add_byte(8'h7F, 1'b1, 1'b1, -16'sd129);
    add_byte(8'h80, 1'b0, 1'b0, '0);
    add_byte(8'hFE, 1'b0, 1'b0, '0);
    add_byte(8'h01, 1'b0, 1'b0, '0);
    // small step: owed outputs spill onto later bytes; rewind mid-sound
    add_regs(16'd1000, 24'd100, AlphaReset);
    add_byte(8'hC3, 1'b1, 1'b1, 16'sd17347);
    add_byte(8'h3C, 1'b0, 1'b0, '0);
    add_byte(8'h5A, 1'b1, 1'b1, -16'sd9638);
    add_byte(8'hA5, 1'b0, 1'b0, '0);
    // longest sound, lightest filter
    add_regs(StepReset, 24'hFFFFFF, 16'd1);
    add_byte(8'h00, 1'b1, 1'b1, -16'sd32768);
    add_byte(8'hFF, 1'b0, 1'b0, '0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REGS)
        set_regs(directed_rows[i].step, directed_rows[i].len, directed_rows[i].alpha);
      else
        send_byte(directed_rows[i].beat, directed_rows[i].typed,
                  directed_rows[i].typed_sample, 1'b0);
    end

    // Random sounds: mostly a first byte and its continuation, some noise
    while (random_sent < RandomBytes) begin
      if (random_sent >= 200 && !held) begin
        // hold the output off while bytes keep coming back to back
        held = 1'b1;
        set_regs(16'd20000, 24'd1000, 16'($urandom));
        hold_req = 1'b1;
        burst    = 1'b1;
        fresh    = 1'b1;
        seq_len  = 24;
      end else begin
        burst = 1'b0;
        if ($urandom_range(0, 2) == 0) begin
          r = $urandom_range(0, 99);
          if (r < 5)       step = 16'd0;
          else if (r < 20) step = 16'($urandom_range(1, 4095));
          else if (r < 25) step = 16'd4096;
          else if (r < 30) step = 16'd65535;
          else             step = 16'($urandom_range(4096, 65535));
          r = $urandom_range(0, 99);
          if (r < 10)      len = 24'd1;
          else if (r < 15) len = 24'hFFFFFF;
          else             len = 24'($urandom_range(2, 150));
          r = $urandom_range(0, 99);
          if (r < 10)      alpha = 16'd0;
          else if (r < 20) alpha = 16'd65535;
          else             alpha = 16'($urandom);
          set_regs(step, len, alpha);
        end
        seq_len = $urandom_range(1, 30);
        fresh   = ($urandom_range(0, 99) < 85);
      end
      for (int k = 0; k < seq_len; k++) begin
        if ($urandom_range(0, 9) == 0)
          beat.source_byte = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else
          beat.source_byte = 8'($urandom);
        beat.first = (k == 0) ? fresh : ($urandom_range(0, 19) == 0);
        send_byte(beat, 1'b0, '0, burst);
        random_sent++;
      end
    end

    // Drain and watch for stray beats
    settle_block();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
